@@ rtl/mcp_pkg.sv @@
`default_nettype none
package mcp_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int OUT_W     = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LETTER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LETTER  = 1'd1;

    localparam logic [7:0] SPEED_LETTER_RST = 8'd115;
    localparam logic [7:0] FREQ_LETTER_RST  = 8'd102;

    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_COLON   = 8'd58;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SPEED = 2'd1;
    localparam logic [1:0] KIND_FREQ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYNTAX  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_NOCOLON = 2'd3;

    localparam logic OP_SPEED = 1'b0;
    localparam logic OP_FREQ  = 1'b1;

    // classified byte handed from the front end to the parser
    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_colon;
        logic       is_minus;
        logic       is_newline;
        logic       is_speed;
        logic       is_freq;
        logic       last;
    } t_token;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [1:0]         status;
        logic [16:0]        pwm_frequency;
        logic signed [10:0] right_speed;
        logic signed [10:0] left_speed;
        logic               op_kind;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/mcp_front.sv @@
`default_nettype none
module mcp_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [mcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                   i_cfg_data,
    input  wire logic [7:0]                   i_byte,
    input  wire logic                         i_last,
    output      mcp_pkg::t_token              o_token
);

    logic [7:0] r_speed_letter;
    logic [7:0] r_freq_letter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_letter <= mcp_pkg::SPEED_LETTER_RST;
            r_freq_letter  <= mcp_pkg::FREQ_LETTER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mcp_pkg::REG_SPEED_LETTER: r_speed_letter <= i_cfg_data;
                mcp_pkg::REG_FREQ_LETTER:  r_freq_letter  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [7:0] digit_off;
    assign digit_off = i_byte - mcp_pkg::CH_ZERO;

    always_comb begin
        o_token.is_digit   = (i_byte >= mcp_pkg::CH_ZERO) && (i_byte <= mcp_pkg::CH_NINE);
        o_token.digit      = digit_off[3:0];
        o_token.is_colon   = (i_byte == mcp_pkg::CH_COLON);
        o_token.is_minus   = (i_byte == mcp_pkg::CH_MINUS);
        o_token.is_newline = (i_byte == mcp_pkg::CH_NEWLINE);
        o_token.is_speed   = (i_byte == r_speed_letter);
        o_token.is_freq    = (i_byte == r_freq_letter);
        o_token.last       = i_last;
    end

endmodule
`default_nettype wire

@@ rtl/mcp_queue.sv @@
`default_nettype none
module mcp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire mcp_pkg::t_token  i_token,
    input  wire logic             i_pop,
    output mcp_pkg::t_token       o_token,
    output mcp_pkg::t_q_stat      o_stat
);

    mcp_pkg::t_token                r_mem [mcp_pkg::Q_DEPTH];
    logic [mcp_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [mcp_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [mcp_pkg::Q_CNT_W-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_token      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == mcp_pkg::Q_CNT_W'(mcp_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule
`default_nettype wire

@@ rtl/mcp_back.sv @@
`default_nettype none
module mcp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mcp_pkg::t_token  i_token,
    input  wire mcp_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    output mcp_pkg::t_result      o_result,
    output logic                  o_valid,
    input  wire logic             i_ready
);

    logic [3:0]  r_pos, n_pos;
    logic [1:0]  r_kind, n_kind;
    logic        r_lneg, n_lneg;
    logic        r_rneg, n_rneg;
    logic [9:0]  r_lacc, n_lacc;
    logic [9:0]  r_racc, n_racc;
    logic [16:0] r_facc, n_facc;
    logic [1:0]  r_err, n_err;
    logic        r_done, n_done;

    logic            r_out_valid;
    mcp_pkg::t_result r_out, n_out;

    logic        out_free;
    logic [3:0]  lstart, rsig, rstart;
    logic [9:0]  lacc_next, racc_next;
    logic [16:0] facc_next;
    logic [1:0]  status;
    logic [10:0] lmag, rmag;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = !i_q_stat.empty && (!i_token.last || out_free);

    // x*10 + d as shift-and-add, wrapped to the accumulator width
    assign lacc_next = (r_lacc << 3) + (r_lacc << 1) + 10'(i_token.digit);
    assign racc_next = (r_racc << 3) + (r_racc << 1) + 10'(i_token.digit);
    assign facc_next = (r_facc << 3) + (r_facc << 1) + 17'(i_token.digit);

    assign lstart = 4'd2 + 4'(r_lneg);
    assign rsig   = lstart + 4'd3;
    assign rstart = rsig + 4'(r_rneg);

    always_comb begin
        n_pos  = r_pos;
        n_kind = r_kind;
        n_lneg = r_lneg;
        n_rneg = r_rneg;
        n_lacc = r_lacc;
        n_racc = r_racc;
        n_facc = r_facc;
        n_err  = r_err;
        n_done = r_done;

        if (r_err == mcp_pkg::ST_OK && !r_done) begin
            if (r_pos == 4'd0) begin
                if (!i_token.is_colon) n_err = mcp_pkg::ST_NOCOLON;
            end else if (r_pos == 4'd1) begin
                if (i_token.is_speed)     n_kind = mcp_pkg::KIND_SPEED;
                else if (i_token.is_freq) n_kind = mcp_pkg::KIND_FREQ;
                else                      n_err  = mcp_pkg::ST_UNKNOWN;
            end else if (r_kind == mcp_pkg::KIND_SPEED) begin
                if (r_pos == 4'd2 && i_token.is_minus) begin
                    n_lneg = 1'b1;
                end else if (r_pos < lstart + 4'd3) begin
                    if (i_token.is_digit) n_lacc = lacc_next;
                    else                  n_err  = mcp_pkg::ST_SYNTAX;
                end else if (r_pos == rsig && !r_rneg && i_token.is_minus) begin
                    n_rneg = 1'b1;
                end else if (r_pos < rstart + 4'd3) begin
                    if (i_token.is_digit) n_racc = racc_next;
                    else                  n_err  = mcp_pkg::ST_SYNTAX;
                end else if (i_token.is_newline) begin
                    n_done = 1'b1;
                end else begin
                    n_err = mcp_pkg::ST_SYNTAX;
                end
            end else begin
                if (r_pos <= 4'd6) begin
                    if (i_token.is_digit) n_facc = facc_next;
                    else                  n_err  = mcp_pkg::ST_SYNTAX;
                end else if (i_token.is_newline) begin
                    n_done = 1'b1;
                end else begin
                    n_err = mcp_pkg::ST_SYNTAX;
                end
            end
            if (r_pos != 4'hF) n_pos = r_pos + 4'd1;
        end

        if (n_err != mcp_pkg::ST_OK)     status = n_err;
        else if (n_done)                 status = mcp_pkg::ST_OK;
        else if (n_kind == mcp_pkg::KIND_NONE) status = mcp_pkg::ST_UNKNOWN;
        else                             status = mcp_pkg::ST_SYNTAX;

        lmag = n_lneg ? (11'd0 - {1'b0, n_lacc}) : {1'b0, n_lacc};
        rmag = n_rneg ? (11'd0 - {1'b0, n_racc}) : {1'b0, n_racc};

        n_out        = '0;
        n_out.status = status;
        if (status == mcp_pkg::ST_OK) begin
            if (n_kind == mcp_pkg::KIND_SPEED) begin
                n_out.op_kind     = mcp_pkg::OP_SPEED;
                n_out.left_speed  = lmag;
                n_out.right_speed = rmag;
            end else begin
                n_out.op_kind       = mcp_pkg::OP_FREQ;
                n_out.pwm_frequency = n_facc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_kind      <= mcp_pkg::KIND_NONE;
            r_lneg      <= 1'b0;
            r_rneg      <= 1'b0;
            r_lacc      <= '0;
            r_racc      <= '0;
            r_facc      <= '0;
            r_err       <= mcp_pkg::ST_OK;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_token.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_token.last) begin
                    // hand off the result and clear for the next command
                    r_pos  <= '0;
                    r_kind <= mcp_pkg::KIND_NONE;
                    r_lneg <= 1'b0;
                    r_rneg <= 1'b0;
                    r_lacc <= '0;
                    r_racc <= '0;
                    r_facc <= '0;
                    r_err  <= mcp_pkg::ST_OK;
                    r_done <= 1'b0;
                end else begin
                    r_pos  <= n_pos;
                    r_kind <= n_kind;
                    r_lneg <= n_lneg;
                    r_rneg <= n_rneg;
                    r_lacc <= n_lacc;
                    r_racc <= n_racc;
                    r_facc <= n_facc;
                    r_err  <= n_err;
                    r_done <= n_done;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_token.last) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

@@ rtl/motor_command_parser.sv @@
// Motor command parser.
// Slave stream: one ASCII byte per transaction in s_tdata[7:0], s_tlast high on
// the final byte of a command. Bytes are classified on entry and queued in a
// four-entry queue; the parser drains the queue one byte per cycle.
// Master stream: one transaction per command, issued for the byte with tlast;
// m_tuser carries the command kind. That byte is written into the queue, then popped
// by the parser, which registers the result and raises m_tvalid.
// Throughput: one byte per cycle sustained; the parser's single output
// register is the only point where a stalled master holds back the queue.
// While a result waits, the final byte of the next command holds at the head
// of the queue; s_tready drops once it and three more bytes are queued.
// Configuration: cfg channel writes the speed letter (index 0) or the frequency
// letter (index 1); o_cfg_ready is always high. Write only while idle.
// Reset (synchronous, active low) empties the queue, clears the parser, drops
// m_tvalid and restores the letters to 's' and 'f'.
`default_nettype none
module motor_command_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output wire logic                          o_cfg_ready,
    input  wire logic [mcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data,
    input  wire logic                          i_s_tvalid,
    output wire logic                          o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,  // [7:0] cmd_byte
    input  wire logic                          i_s_tlast,  // end_of_command
    output wire logic                          o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [10:0] left_speed, [21:11] right_speed, [38:22] pwm_frequency,
    // [40:39] status, [47:41] zero
    output wire logic [mcp_pkg::OUT_W-1:0]     o_m_tdata,
    output wire logic                          o_m_tuser   // [0] op_kind
);

    mcp_pkg::t_token  front_token;
    mcp_pkg::t_token  q_token;
    mcp_pkg::t_q_stat q_stat;
    mcp_pkg::t_result result;
    logic             push;
    logic             pop;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !q_stat.full;
    assign push        = i_s_tvalid && o_s_tready;

    mcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_token     (front_token)
    );

    mcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_token),
        .i_pop   (pop),
        .o_token (q_token),
        .o_stat  (q_stat)
    );

    mcp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_token  (q_token),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_result (result),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready)
    );

    assign o_m_tdata = {7'd0, result.status, result.pwm_frequency, result.right_speed,
                        result.left_speed};
    assign o_m_tuser = result.op_kind;

`ifndef SYNTHESIS
    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && result.status != mcp_pkg::ST_OK) |->
        (result.op_kind == 1'b0 && result.left_speed == '0 &&
         result.right_speed == '0 && result.pwm_frequency == '0))
        else $error("faulted result carries nonzero values");

    a_freq_no_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && result.op_kind == mcp_pkg::OP_FREQ) |->
        (result.left_speed == '0 && result.right_speed == '0))
        else $error("frequency result carries speed values");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !pop)
        else $error("parser drained an empty queue");

    a_reset_drops_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_motor_command_parser.sv @@
module tb_motor_command_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RES_W       = $bits(mcp_pkg::t_result);
    localparam int QUIET_LIMIT = 4000;
    localparam int IDLE_WAIT   = 8;

    // Tracks the command being parsed and holds the decodes still owed by the block.
    class command_decode_sb;
        logic [7:0]  speed_letter;
        logic [7:0]  freq_letter;
        logic [3:0]  position;
        logic [1:0]  kind;
        logic        left_neg;
        logic        right_neg;
        logic [9:0]  left_acc;
        logic [9:0]  right_acc;
        logic [16:0] freq_acc;
        logic [1:0]  fault;
        logic        done;
        mcp_pkg::t_result pending_decodes[$];
        int          errors;

        function new();
            speed_letter = mcp_pkg::SPEED_LETTER_RST;
            freq_letter  = mcp_pkg::FREQ_LETTER_RST;
            errors       = 0;
            clear();
        endfunction

        function void clear();
            position  = '0;
            kind      = mcp_pkg::KIND_NONE;
            left_neg  = 1'b0;
            right_neg = 1'b0;
            left_acc  = '0;
            right_acc = '0;
            freq_acc  = '0;
            fault     = mcp_pkg::ST_OK;
            done      = 1'b0;
        endfunction

        function void set_letter(logic [mcp_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == mcp_pkg::REG_SPEED_LETTER) begin
                speed_letter = val;
            end else if (idx == mcp_pkg::REG_FREQ_LETTER) begin
                freq_letter = val;
            end
        endfunction

        function int shift_digit(int acc, logic [7:0] b);
            if (b < mcp_pkg::CH_ZERO || b > mcp_pkg::CH_NINE) begin
                fault = mcp_pkg::ST_SYNTAX;
                return acc;
            end
            return acc * 10 + int'(b - mcp_pkg::CH_ZERO);
        endfunction

        function logic [10:0] apply_sign(logic neg, logic [9:0] mag);
            return neg ? (11'd0 - {1'b0, mag}) : {1'b0, mag};
        endfunction

        function void parse_byte(logic [7:0] b);
            int lstart;
            int rsig;
            int rstart;
            lstart = 2 + int'(left_neg);
            rsig   = lstart + 3;
            rstart = rsig + int'(right_neg);
            if (position == 0) begin
                if (b != mcp_pkg::CH_COLON) fault = mcp_pkg::ST_NOCOLON;
            end else if (position == 1) begin
                // speed wins when both letters match
                if (b == speed_letter) kind = mcp_pkg::KIND_SPEED;
                else if (b == freq_letter) kind = mcp_pkg::KIND_FREQ;
                else fault = mcp_pkg::ST_UNKNOWN;
            end else if (kind == mcp_pkg::KIND_SPEED) begin
                if (position == 2 && b == mcp_pkg::CH_MINUS) begin
                    left_neg = 1'b1;
                end else if (int'(position) < lstart + 3) begin
                    left_acc = 10'(shift_digit(int'(left_acc), b));
                end else if (int'(position) == rsig && !right_neg
                             && b == mcp_pkg::CH_MINUS) begin
                    right_neg = 1'b1;
                end else if (int'(position) < rstart + 3) begin
                    right_acc = 10'(shift_digit(int'(right_acc), b));
                end else if (b == mcp_pkg::CH_NEWLINE) begin
                    done = 1'b1;
                end else begin
                    fault = mcp_pkg::ST_SYNTAX;
                end
            end else begin
                if (position <= 6) freq_acc = 17'(shift_digit(int'(freq_acc), b));
                else if (b == mcp_pkg::CH_NEWLINE) done = 1'b1;
                else fault = mcp_pkg::ST_SYNTAX;
            end
            if (position < 15) position = position + 4'd1;
        endfunction

        function void decode_byte(logic [7:0] b, logic last);
            mcp_pkg::t_result r;
            logic [1:0]       st;
            // hold off parsing after a fault or after the closing newline
            if (fault == mcp_pkg::ST_OK && !done) parse_byte(b);
            if (!last) return;
            r = '0;
            if (fault != mcp_pkg::ST_OK) st = fault;
            else if (done) st = mcp_pkg::ST_OK;
            else if (kind == mcp_pkg::KIND_NONE) st = mcp_pkg::ST_UNKNOWN;
            else st = mcp_pkg::ST_SYNTAX;
            if (st == mcp_pkg::ST_OK) begin
                if (kind == mcp_pkg::KIND_SPEED) begin
                    r.op_kind     = mcp_pkg::OP_SPEED;
                    r.left_speed  = apply_sign(left_neg, left_acc);
                    r.right_speed = apply_sign(right_neg, right_acc);
                end else begin
                    r.op_kind       = mcp_pkg::OP_FREQ;
                    r.pwm_frequency = freq_acc;
                end
            end
            r.status = st;
            pending_decodes.push_back(r);
            clear();
        endfunction

        function void match_result(logic [mcp_pkg::OUT_W-1:0] data, logic user);
            mcp_pkg::t_result got;
            mcp_pkg::t_result want;
            got = {data[RES_W-2:0], user};
            if (pending_decodes.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h with no command pending", data);
                return;
            end
            want = pending_decodes.pop_front();
            if (got.op_kind !== want.op_kind || got.left_speed !== want.left_speed
                    || got.right_speed !== want.right_speed
                    || got.pwm_frequency !== want.pwm_frequency
                    || got.status !== want.status
                    || data[mcp_pkg::OUT_W-1:RES_W-1] !== '0) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected kind %0d left %0d right %0d freq %0d status %0d",
                             want.op_kind, want.left_speed, want.right_speed,
                             want.pwm_frequency, want.status);
                    $display("  actual kind %0d left %0d right %0d freq %0d status %0d pad %h",
                             got.op_kind, got.left_speed, got.right_speed,
                             got.pwm_frequency, got.status, data[mcp_pkg::OUT_W-1:RES_W-1]);
                end
            end
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [mcp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]                    i_cfg_data  = '0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata   = '0;
    logic                          i_s_tlast   = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    logic [mcp_pkg::OUT_W-1:0]     o_m_tdata;
    logic                          o_m_tuser;

    command_decode_sb sb = new();
    logic [7:0]       frame[$];
    int               bytes_sent     = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               quiet_cycles   = 0;

    motor_command_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.match_result(o_m_tdata, o_m_tuser);
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        // idle the sender at random, drawing again after each idle clock
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.decode_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    endtask

    // Drop valid, drain every owed decode, then let the pipeline settle.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending_decodes.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_letters(logic [7:0] speed, logic [7:0] freq);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= mcp_pkg::REG_SPEED_LETTER;
        i_cfg_data  <= speed;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_letter(mcp_pkg::REG_SPEED_LETTER, speed);
        i_cfg_index <= mcp_pkg::REG_FREQ_LETTER;
        i_cfg_data  <= freq;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_letter(mcp_pkg::REG_FREQ_LETTER, freq);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_value(int max_val);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return max_val;
            default: return $urandom_range(0, max_val);
        endcase
    endfunction

    function automatic void push_digits(int count, int value);
        int scale;
        scale = 1;
        repeat (count - 1) scale *= 10;
        for (int k = 0; k < count; k++) begin
            frame.push_back(8'(int'(mcp_pkg::CH_ZERO) + (value / scale) % 10));
            scale /= 10;
        end
    endfunction

    function automatic void add_speed();
        frame.push_back(mcp_pkg::CH_COLON);
        frame.push_back(sb.speed_letter);
        if ($urandom_range(0, 1)) frame.push_back(mcp_pkg::CH_MINUS);
        push_digits(3, pick_value(999));
        if ($urandom_range(0, 1)) frame.push_back(mcp_pkg::CH_MINUS);
        push_digits(3, pick_value(999));
        frame.push_back(mcp_pkg::CH_NEWLINE);
    endfunction

    function automatic void add_freq();
        frame.push_back(mcp_pkg::CH_COLON);
        frame.push_back(sb.freq_letter);
        push_digits(5, pick_value(99999));
        frame.push_back(mcp_pkg::CH_NEWLINE);
    endfunction

    function automatic void build_frame();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        frame.delete();
        if (pick < 35) begin
            add_speed();
        end else if (pick < 60) begin
            add_freq();
        end else if (pick < 70) begin
            // corrupt one byte of a good command
            if (pick[0]) add_speed(); else add_freq();
            frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick < 78) begin
            // end the command early
            if (pick[0]) add_speed(); else add_freq();
            repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
        end else if (pick < 85) begin
            // junk after the newline
            if (pick[0]) add_speed(); else add_freq();
            repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
            if (pick[0]) add_speed(); else add_freq();
            do b = 8'($urandom_range(0, 255)); while (b == mcp_pkg::CH_COLON);
            frame[0] = b;
        end else if (pick < 95) begin
            frame.push_back(mcp_pkg::CH_COLON);
            do b = 8'($urandom_range(0, 255));
            while (b == sb.speed_letter || b == sb.freq_letter);
            frame.push_back(b);
            repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 14)) frame.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic run_traffic(int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            build_frame();
            send_frame();
        end
    endtask

    function automatic void set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
    endfunction

    initial begin
        logic [7:0] v;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        frame = {mcp_pkg::CH_COLON, mcp_pkg::SPEED_LETTER_RST, mcp_pkg::CH_MINUS,
                 mcp_pkg::CH_NINE, mcp_pkg::CH_NINE, mcp_pkg::CH_NINE, mcp_pkg::CH_MINUS,
                 mcp_pkg::CH_NINE, mcp_pkg::CH_NINE, mcp_pkg::CH_NINE, mcp_pkg::CH_NEWLINE};
        send_frame();
        frame = {mcp_pkg::CH_COLON, mcp_pkg::FREQ_LETTER_RST, mcp_pkg::CH_NINE,
                 mcp_pkg::CH_NINE, mcp_pkg::CH_NINE, mcp_pkg::CH_NINE, mcp_pkg::CH_NINE,
                 mcp_pkg::CH_NEWLINE};
        send_frame();
        // negative zero, then bytes past the newline
        frame = {mcp_pkg::CH_COLON, mcp_pkg::SPEED_LETTER_RST, mcp_pkg::CH_MINUS,
                 mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO,
                 mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO, mcp_pkg::CH_NEWLINE, 8'h00, 8'hFF};
        send_frame();
        frame = {mcp_pkg::CH_COLON};
        send_frame();
        frame = {8'hFF};
        send_frame();
        frame = {mcp_pkg::CH_COLON, 8'h00};
        send_frame();
        frame = {mcp_pkg::CH_COLON, mcp_pkg::FREQ_LETTER_RST, mcp_pkg::CH_ZERO,
                 mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO,
                 mcp_pkg::CH_MINUS};
        send_frame();

        for (int s = 0; s < 5; s++) begin
            case (s)
                1: write_letters(8'd0, 8'd255);
                2: begin
                    v = 8'($urandom_range(0, 255));
                    write_letters(v, v);
                end
                3: write_letters(8'd255, 8'd0);
                4: write_letters(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: ;
            endcase
            for (int mode = 0; mode < 4; mode++) begin
                set_idling(mode);
                run_traffic(25);
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_decodes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
